/* rtl/core/npc_pkg.sv */
// shared constants and types of the nearest palette colour core
package npc_pkg;

	localparam int PALETTE_DEPTH = 256;
	localparam int ADDR_W        = $clog2(PALETTE_DEPTH);
	localparam int COMP_W        = 8;
	localparam int IDX_W         = 8;
	localparam int COUNT_W       = 9;
	localparam int SQ_W          = 2 * COMP_W;
	localparam int DIST_W        = 18;
	localparam int MAX_COMP      = (1 << COMP_W) - 1;
	localparam int MAX_DIST      = 4 * MAX_COMP * MAX_COMP;

	typedef enum logic {
		CMD_WRITE    = 1'b0,
		CMD_CLASSIFY = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [COMP_W-1:0] red;
		logic [COMP_W-1:0] green;
		logic [COMP_W-1:0] blue;
		logic [COMP_W-1:0] alpha;
	} rgba_t;

	// travels alongside each palette entry through the read and distance stages
	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] idx;
		logic              last;
	} tag_t;

endpackage

/* rtl/core/npc_palette_ram.sv */
// palette memory, one write port and one registered read port
module npc_palette_ram (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [npc_pkg::ADDR_W-1:0] wr_addr,
	input  npc_pkg::rgba_t             wr_data,
	input  logic                       rd_en,
	input  logic [npc_pkg::ADDR_W-1:0] rd_addr,
	output npc_pkg::rgba_t             rd_data
);

	npc_pkg::rgba_t mem_q [npc_pkg::PALETTE_DEPTH];
	npc_pkg::rgba_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/core/npc_dist_unit.sv */
// shared two-stage squared rgba distance unit, one palette entry per cycle
module npc_dist_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  npc_pkg::tag_t              tag_in,
	input  npc_pkg::rgba_t             entry,
	input  npc_pkg::rgba_t             pixel,
	output npc_pkg::tag_t              tag_out,
	output logic [npc_pkg::DIST_W-1:0] dist_sum
);

	logic [npc_pkg::COMP_W-1:0] dr, dg, db, da;
	logic [npc_pkg::SQ_W-1:0]   sq_r_s1, sq_g_s1, sq_b_s1, sq_a_s1;
	logic [npc_pkg::DIST_W-1:0] dist_s2;
	npc_pkg::tag_t              tag_s1, tag_s2;

	// absolute component differences
	assign dr = (entry.red   >= pixel.red)   ? entry.red   - pixel.red   : pixel.red   - entry.red;
	assign dg = (entry.green >= pixel.green) ? entry.green - pixel.green : pixel.green - entry.green;
	assign db = (entry.blue  >= pixel.blue)  ? entry.blue  - pixel.blue  : pixel.blue  - entry.blue;
	assign da = (entry.alpha >= pixel.alpha) ? entry.alpha - pixel.alpha : pixel.alpha - entry.alpha;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		sq_r_s1 <= npc_pkg::SQ_W'(dr) * npc_pkg::SQ_W'(dr);
		sq_g_s1 <= npc_pkg::SQ_W'(dg) * npc_pkg::SQ_W'(dg);
		sq_b_s1 <= npc_pkg::SQ_W'(db) * npc_pkg::SQ_W'(db);
		sq_a_s1 <= npc_pkg::SQ_W'(da) * npc_pkg::SQ_W'(da);
		dist_s2 <= npc_pkg::DIST_W'(sq_r_s1) + npc_pkg::DIST_W'(sq_g_s1)
			+ npc_pkg::DIST_W'(sq_b_s1) + npc_pkg::DIST_W'(sq_a_s1);
	end

	assign tag_out  = tag_s2;
	assign dist_sum = dist_s2;

endmodule

/* rtl/core/nearest_palette_color_core.sv */
// top level: sequencer, best-match tracking and result register of the palette search
//
//  channel   signals                                       direction
//  input     in_valid/in_ready, command, entry_index,      in
//            red, green, blue, alpha
//  output    out_valid/out_ready, best_index,              out
//            best_distance
//  config    cfg_wr_en, cfg_wr_data (palette_count)        in
//
// a write command needs no further work: the entry goes into the palette memory at the transfer
// a classify command reads one entry per cycle after the transfer, palette_count entries in
// all, then two distance stages, compare and result load follow before out_valid rises (a
// count of zero reads as 1, above 256 as 256)
// reset clears the sequencer, the result register and sets palette_count to 1; the palette
// itself holds no reset value and must be written before it is searched
// a held result does not block the next transfer; a finished search waits until its result
// is loaded into the result register, which needs that register empty or out_ready, first
module nearest_palette_color_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [npc_pkg::COUNT_W-1:0] cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        command,
	input  logic [7:0]                  entry_index,
	input  logic [7:0]                  red,
	input  logic [7:0]                  green,
	input  logic [7:0]                  blue,
	input  logic [7:0]                  alpha,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [npc_pkg::IDX_W-1:0]   best_index,
	output logic [npc_pkg::DIST_W-1:0]  best_distance
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN
	} state_t;

	state_t                      state_q;
	logic [npc_pkg::COUNT_W-1:0] count_q;
	logic [npc_pkg::ADDR_W-1:0]  rd_cnt_q;
	logic [npc_pkg::ADDR_W-1:0]  last_q;
	npc_pkg::rgba_t              pix_q;
	logic [npc_pkg::ADDR_W-1:0]  best_idx_q;
	logic [npc_pkg::DIST_W-1:0]  best_dist_q;
	logic                        res_pend_q;
	logic                        out_valid_q;
	logic [npc_pkg::IDX_W-1:0]   out_idx_q;
	logic [npc_pkg::DIST_W-1:0]  out_dist_q;
	npc_pkg::tag_t               tag_s1;

	logic                        accept;
	logic                        issue;
	logic [npc_pkg::ADDR_W-1:0]  last_idx;
	npc_pkg::rgba_t              in_rgba;
	npc_pkg::rgba_t              entry;
	npc_pkg::tag_t               tag_rd;
	npc_pkg::tag_t               tag_s3;
	logic [npc_pkg::DIST_W-1:0]  dist_s3;
	logic                        take;
	logic                        out_load;
	logic                        wr_en;

	assign in_ready = (state_q == ST_IDLE) && !res_pend_q;
	assign accept   = in_valid && in_ready;
	assign issue    = (state_q == ST_ISSUE);
	assign in_rgba  = '{red: red, green: green, blue: blue, alpha: alpha};

	// entries beyond the memory are dropped
	assign wr_en = accept && (command == npc_pkg::CMD_WRITE)
		&& ({1'b0, entry_index} < npc_pkg::COUNT_W'(npc_pkg::PALETTE_DEPTH));

	// count of zero searches entry zero, too large a count saturates to the depth
	always_comb begin
		if (count_q == '0) begin
			last_idx = '0;
		end else if (count_q > npc_pkg::COUNT_W'(npc_pkg::PALETTE_DEPTH)) begin
			last_idx = npc_pkg::ADDR_W'(npc_pkg::PALETTE_DEPTH - 1);
		end else begin
			last_idx = npc_pkg::ADDR_W'(count_q - 1'b1);
		end
	end

	assign tag_rd = '{valid: issue, idx: rd_cnt_q, last: (rd_cnt_q == last_q)};

	npc_palette_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (npc_pkg::ADDR_W'(entry_index)),
		.wr_data (in_rgba),
		.rd_en   (issue),
		.rd_addr (rd_cnt_q),
		.rd_data (entry)
	);

	npc_dist_unit u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.tag_in   (tag_s1),
		.entry    (entry),
		.pixel    (pix_q),
		.tag_out  (tag_s3),
		.dist_sum (dist_s3)
	);

	// first entry always taken, later ones only when strictly nearer (lowest index on ties)
	assign take     = tag_s3.valid && ((tag_s3.idx == '0) || (dist_s3 < best_dist_q));
	assign out_load = res_pend_q && (!out_valid_q || out_ready);

	// tag for the memory read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= tag_rd;
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= npc_pkg::COUNT_W'(1);
			rd_cnt_q    <= '0;
			last_q      <= '0;
			res_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				count_q <= cfg_wr_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (command == npc_pkg::CMD_CLASSIFY)) begin
						rd_cnt_q <= '0;
						last_q   <= last_idx;
						state_q  <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
					if (rd_cnt_q == last_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (tag_s3.valid && tag_s3.last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (tag_s3.valid && tag_s3.last) begin
				res_pend_q <= 1'b1;
			end else if (out_load) begin
				res_pend_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q <= in_rgba;
		end
		if (take) begin
			best_idx_q  <= tag_s3.idx;
			best_dist_q <= dist_s3;
		end
		if (out_load) begin
			out_idx_q  <= npc_pkg::IDX_W'(best_idx_q);
			out_dist_q <= best_dist_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign best_index    = out_idx_q;
	assign best_distance = out_dist_q;

`ifndef NO_ASSERTIONS
	// a result only appears after a finished search
	a_result_from_search: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(res_pend_q))
		else $error("result shown without a finished search");

	// distances only leave the shared unit while a search is running
	a_dist_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s3.valid |-> (state_q != ST_IDLE))
		else $error("distance stage active outside a search");

	// the reported distance never exceeds the largest squared rgba distance
	a_dist_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_dist_q <= npc_pkg::DIST_W'(npc_pkg::MAX_DIST)))
		else $error("best distance out of range");
`endif

endmodule
